FILE: src/call_trace_recorder_macros.svh
// assertion macros for the call trace recorder
`ifndef CALL_TRACE_RECORDER_MACROS_SVH
`define CALL_TRACE_RECORDER_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication, checked out of reset
`define CTR_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication, checked out of reset
`define CTR_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define CTR_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define CTR_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

FILE: src/ctr_pkg.sv
// shared types and constants for the call trace recorder
package ctr_pkg;

  // ring sizes are powers of two: slots come from the low counter bits
  localparam int STACK_DEPTH = 512;
  localparam int TRACE_DEPTH = 256;
  localparam int TURN_DEPTH  = 1024;

  localparam int STK_AW = $clog2(STACK_DEPTH);
  localparam int SP_W   = $clog2(STACK_DEPTH + 1);
  localparam int TRC_AW = $clog2(TRACE_DEPTH);
  localparam int TRC_CW = $clog2(TRACE_DEPTH + 1);
  localparam int TRN_AW = $clog2(TURN_DEPTH);
  localparam int TRN_CW = $clog2(TURN_DEPTH + 1);

  localparam logic [31:0] CALL_MARK  = 32'h8000_0000;
  localparam logic [7:0]  DATA_MARK  = 8'h80;

  typedef enum logic [2:0] {
    CMD_ENTER    = 3'd0,
    CMD_EXIT     = 3'd1,
    CMD_DATA     = 3'd2,
    CMD_BEGIN    = 3'd3,
    CMD_COMPLETE = 3'd4,
    CMD_READ     = 3'd5
  } cmd_t;

  typedef enum logic [1:0] {
    REG_GLOBAL_EN  = 2'd0,
    REG_THREAD_EN  = 2'd1,
    REG_CTX_ATTACH = 2'd2
  } reg_idx_t;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  typedef struct packed {
    logic [2:0]  command;
    logic [31:0] call_target;
    logic [31:0] return_address;
    logic [31:0] data_word;
    logic [7:0]  read_offset;
  } in_item_t;

  typedef struct packed {
    logic        accepted;
    logic [31:0] popped_address;
    logic [31:0] entry_word;
    logic [7:0]  entry_depth;
    logic        entry_valid;
    logic [TRC_CW-1:0] trace_count;
    logic [TRN_CW-1:0] turn_count;
  } out_item_t;

  typedef struct packed {
    logic [1:0] index;
    logic       wdata;
  } cfg_wr_t;

  typedef struct packed {
    logic [7:0]  depth;
    logic [31:0] word;
  } trace_slot_t;

  typedef struct packed {
    logic [31:0] id;
    logic [31:0] head;
  } turn_slot_t;

endpackage

FILE: src/ctr_if.sv
// valid/ready channel interfaces for the call trace recorder
interface ctr_in_if;
  logic              valid;
  logic              ready;
  ctr_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ctr_out_if;
  logic               valid;
  logic               ready;
  ctr_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ctr_cfg_if;
  logic             valid;
  logic             ready;
  ctr_pkg::cfg_wr_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: src/call_trace_recorder.sv
// call trace recorder top level: shadow stack, trace ring and turn ring
//
// usage:
//   in_ch carries one command transaction (enter, exit, data, begin turn,
//   complete turn, read entry); out_ch returns exactly one result
//   transaction per command, in order. cfg_ch writes the three enable
//   registers (index 0 global, 1 thread, 2 context attached); it is always
//   ready and should be written only while the block is idle.
// timing:
//   the accept cycle issues the memory reads (stack top, trace slot, oldest
//   turn); the command then modifies and writes back and loads the result
//   register, once no older result is held. a new command is taken only
//   after the previous one is written back; in_ch.ready is high only in idle.
// stalls:
//   the result register holds while out_ch.ready is low; a new command is
//   still taken, but its write-back waits until the held result leaves.
// reset:
//   pointers, counters and enables take their reset values on a synchronous
//   reset; the ring memories are not cleared, only written slots are used.
`include "call_trace_recorder_macros.svh"

module call_trace_recorder (
  input logic      clk,
  input logic      rst_n,
  ctr_in_if.sink   in_ch,
  ctr_out_if.source out_ch,
  ctr_cfg_if.sink  cfg_ch
);

  // memories
  logic [31:0]              stack_mem [ctr_pkg::STACK_DEPTH];
  ctr_pkg::trace_slot_t     trace_mem [ctr_pkg::TRACE_DEPTH];
  ctr_pkg::turn_slot_t      turn_mem  [ctr_pkg::TURN_DEPTH];

  logic [31:0]              stk_rdata_r;
  ctr_pkg::trace_slot_t     trc_rdata_r;
  ctr_pkg::turn_slot_t      trn_rdata_r;

  logic                     stk_we;
  logic [ctr_pkg::STK_AW-1:0] stk_waddr, stk_raddr;
  logic [31:0]              stk_wdata;
  logic                     trc_we;
  logic [ctr_pkg::TRC_AW-1:0] trc_waddr, trc_raddr;
  ctr_pkg::trace_slot_t     trc_wdata;
  logic                     trn_we;
  logic [ctr_pkg::TRN_AW-1:0] trn_waddr, trn_raddr;
  ctr_pkg::turn_slot_t      trn_wdata;

  // control and config state
  ctr_pkg::state_t          state_r, state_nxt;
  ctr_pkg::in_item_t        item_r, item_nxt;
  logic [ctr_pkg::SP_W-1:0] sp_r, sp_nxt;
  logic [31:0]              trace_head_r, trace_head_nxt;
  logic [31:0]              trace_tail_r, trace_tail_nxt;
  logic [ctr_pkg::TRN_CW-1:0] turn_head_r, turn_head_nxt;
  logic [ctr_pkg::TRN_CW-1:0] turn_tail_r, turn_tail_nxt;
  logic [31:0]              turn_ctr_r, turn_ctr_nxt;
  logic [31:0]              done_ctr_r, done_ctr_nxt;
  logic                     global_en_r, thread_en_r, ctx_r;
  logic                     out_valid_r, out_valid_nxt;
  ctr_pkg::out_item_t       out_data_r, out_data_nxt;

  logic                     in_accept;
  logic                     log_on;
  logic [31:0]              trace_cnt, trace_cnt_nxt, rd_sum, head_gap;
  logic [ctr_pkg::TRN_CW-1:0] turn_cnt, turn_cnt_nxt;

  assign in_ch.ready  = (state_r == ctr_pkg::S_IDLE);
  assign in_accept    = in_ch.valid && in_ch.ready;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;
  assign cfg_ch.ready = 1'b1;

  assign log_on    = ctx_r && global_en_r && thread_en_r;
  assign trace_cnt = trace_head_r - trace_tail_r;
  assign turn_cnt  = turn_head_r - turn_tail_r;
  assign head_gap  = trn_rdata_r.head - trace_tail_r;

  // read addresses come from the pointers; the trace slot adds the incoming read offset
  assign stk_raddr = ctr_pkg::STK_AW'(sp_r - 1'b1);
  assign rd_sum    = trace_tail_r + {24'd0, in_ch.data.read_offset};
  assign trc_raddr = rd_sum[ctr_pkg::TRC_AW-1:0];
  assign trn_raddr = turn_tail_r[ctr_pkg::TRN_AW-1:0];

  always_ff @(posedge clk) begin
    if (stk_we) begin
      stack_mem[stk_waddr] <= stk_wdata;
    end
    if (in_accept) begin
      stk_rdata_r <= stack_mem[stk_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (trc_we) begin
      trace_mem[trc_waddr] <= trc_wdata;
    end
    if (in_accept) begin
      trc_rdata_r <= trace_mem[trc_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (trn_we) begin
      turn_mem[trn_waddr] <= trn_wdata;
    end
    if (in_accept) begin
      trn_rdata_r <= turn_mem[trn_raddr];
    end
  end

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      global_en_r <= 1'b1;
      thread_en_r <= 1'b0;
      ctx_r       <= 1'b0;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.data.index)
        ctr_pkg::REG_GLOBAL_EN:  global_en_r <= cfg_ch.data.wdata;
        ctr_pkg::REG_THREAD_EN:  thread_en_r <= cfg_ch.data.wdata;
        ctr_pkg::REG_CTX_ATTACH: ctx_r       <= cfg_ch.data.wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ctr_pkg::S_IDLE;
      sp_r         <= '0;
      trace_head_r <= '0;
      trace_tail_r <= '0;
      turn_head_r  <= '0;
      turn_tail_r  <= '0;
      turn_ctr_r   <= '0;
      done_ctr_r   <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      sp_r         <= sp_nxt;
      trace_head_r <= trace_head_nxt;
      trace_tail_r <= trace_tail_nxt;
      turn_head_r  <= turn_head_nxt;
      turn_tail_r  <= turn_tail_nxt;
      turn_ctr_r   <= turn_ctr_nxt;
      done_ctr_r   <= done_ctr_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    out_data_r <= out_data_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    item_nxt       = item_r;
    sp_nxt         = sp_r;
    trace_head_nxt = trace_head_r;
    trace_tail_nxt = trace_tail_r;
    turn_head_nxt  = turn_head_r;
    turn_tail_nxt  = turn_tail_r;
    turn_ctr_nxt   = turn_ctr_r;
    done_ctr_nxt   = done_ctr_r;
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    stk_we         = 1'b0;
    stk_waddr      = sp_r[ctr_pkg::STK_AW-1:0];
    stk_wdata      = item_r.return_address;
    trc_we         = 1'b0;
    trc_waddr      = trace_head_r[ctr_pkg::TRC_AW-1:0];
    trc_wdata      = '{depth: {1'b0, sp_r[6:0]},
                       word: item_r.call_target | ctr_pkg::CALL_MARK};
    trn_we         = 1'b0;
    trn_waddr      = turn_head_r[ctr_pkg::TRN_AW-1:0];
    trn_wdata      = '{id: turn_ctr_r + 32'd1, head: trace_head_r};

    // result leaves
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ctr_pkg::S_IDLE: begin
        if (in_accept) begin
          item_nxt  = in_ch.data;
          state_nxt = ctr_pkg::S_EXEC;
        end
      end
      ctr_pkg::S_EXEC: begin
        // write-back waits while an older result is held
        if (!out_valid_r || out_ch.ready) begin
          out_data_nxt = '0;
          out_data_nxt.accepted = 1'b1;
          case (item_r.command)
            ctr_pkg::CMD_ENTER: begin
              if (sp_r == ctr_pkg::SP_W'(ctr_pkg::STACK_DEPTH)) begin
                out_data_nxt.accepted = 1'b0;
              end else begin
                stk_we = 1'b1;
                sp_nxt = sp_r + 1'b1;
                if (log_on) begin
                  trc_we         = 1'b1;
                  trace_head_nxt = trace_head_r + 32'd1;
                  if (trace_cnt == 32'(ctr_pkg::TRACE_DEPTH)) begin
                    trace_tail_nxt = trace_tail_r + 32'd1;
                  end
                end
              end
            end
            ctr_pkg::CMD_EXIT: begin
              if (sp_r != '0) begin
                sp_nxt = sp_r - 1'b1;
                out_data_nxt.popped_address = stk_rdata_r;
              end
            end
            ctr_pkg::CMD_DATA: begin
              trc_wdata = '{depth: ctr_pkg::DATA_MARK | {1'b0, sp_r[6:0]},
                            word: item_r.data_word};
              if (log_on) begin
                trc_we         = 1'b1;
                trace_head_nxt = trace_head_r + 32'd1;
                if (trace_cnt == 32'(ctr_pkg::TRACE_DEPTH)) begin
                  trace_tail_nxt = trace_tail_r + 32'd1;
                end
              end
            end
            ctr_pkg::CMD_BEGIN: begin
              if (ctx_r) begin
                trn_we        = 1'b1;
                turn_ctr_nxt  = turn_ctr_r + 32'd1;
                turn_head_nxt = turn_head_r + 1'b1;
                if (turn_cnt == ctr_pkg::TRN_CW'(ctr_pkg::TURN_DEPTH)) begin
                  turn_tail_nxt = turn_tail_r + 1'b1;
                end
              end
            end
            ctr_pkg::CMD_COMPLETE: begin
              if (ctx_r) begin
                done_ctr_nxt = done_ctr_r + 32'd1;
                if (turn_cnt != '0 && trn_rdata_r.id == done_ctr_r + 32'd1) begin
                  turn_tail_nxt = turn_tail_r + 1'b1;
                  // only move the tail forward, never back over live entries
                  if (!head_gap[31]) begin
                    trace_tail_nxt = trn_rdata_r.head;
                  end
                end
              end
            end
            ctr_pkg::CMD_READ: begin
              if ({24'd0, item_r.read_offset} < trace_cnt) begin
                out_data_nxt.entry_word  = trc_rdata_r.word;
                out_data_nxt.entry_depth = trc_rdata_r.depth;
                out_data_nxt.entry_valid = 1'b1;
              end
            end
            default: ;
          endcase
          out_data_nxt.trace_count = trace_cnt_nxt[ctr_pkg::TRC_CW-1:0];
          out_data_nxt.turn_count  = turn_cnt_nxt;
          out_valid_nxt = 1'b1;
          state_nxt     = ctr_pkg::S_IDLE;
        end
      end
      default: state_nxt = ctr_pkg::S_IDLE;
    endcase
  end

  assign trace_cnt_nxt = trace_head_nxt - trace_tail_nxt;
  assign turn_cnt_nxt  = turn_head_nxt - turn_tail_nxt;

  // checks
  `CTR_ASSERT_IMP(a_sp_range, clk, rst_n, 1'b1, sp_r <= ctr_pkg::SP_W'(ctr_pkg::STACK_DEPTH), "stack pointer beyond depth")
  `CTR_ASSERT_IMP(a_trace_cnt, clk, rst_n, 1'b1, trace_cnt <= 32'(ctr_pkg::TRACE_DEPTH), "trace ring overfilled")
  `CTR_ASSERT_IMP(a_turn_cnt, clk, rst_n, 1'b1, turn_cnt <= ctr_pkg::TRN_CW'(ctr_pkg::TURN_DEPTH), "turn ring overfilled")
  `CTR_ASSERT_NXT(a_accept_exec, clk, rst_n, in_accept, state_r == ctr_pkg::S_EXEC, "accepted transaction not executed")

endmodule
